// ===== sv/pdll_pkg.sv =====
package pdll_pkg;

  typedef enum logic [2:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_TAIL = 3'd1,
    MODE_INS_POS  = 3'd2,
    MODE_DEL_POS  = 3'd3,
    MODE_DUMP     = 3'd4
  } mode_e;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_RD,
    S_WAIT,
    S_WALK,
    S_LINK,
    S_DUMP_RD,
    S_DUMP_WAIT,
    S_DUMP_OUT,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT_STEP,
    OP_LOAD,
    OP_START,
    OP_READ,
    OP_STEP,
    OP_INS_HEAD,
    OP_INS_TAIL,
    OP_INS_MID,
    OP_DEL,
    OP_DUMP_EMIT,
    OP_RESULT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] status;
  } pdll_cmd_t;

  typedef struct packed {
    logic init_done;
    logic full;
    logic empty;
    logic walk_done;
    logic cur_valid;
    logic prv_valid;
    logic nx_valid;
    logic del_head;
  } pdll_sts_t;

endpackage

// ===== sv/pdll_ram.sv =====
module pdll_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/pdll_ctrl.sv =====
module pdll_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            mode_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pdll_pkg::pdll_sts_t   sts_i,
  output pdll_pkg::pdll_cmd_t   cmd_o
);
  import pdll_pkg::*;

  state_e state_q, state_d;
  logic [2:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      mode_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) mode_q <= mode_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: if (sts_i.init_done) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        case (mode_q)
          MODE_INS_HEAD, MODE_INS_TAIL:
            state_d = sts_i.full ? S_OUT : S_LINK;
          MODE_INS_POS: state_d = sts_i.full ? S_OUT : S_WALK;
          MODE_DEL_POS: state_d = sts_i.empty ? S_OUT : S_WALK;
          MODE_DUMP: state_d = sts_i.empty ? S_OUT : S_DUMP_RD;
          default: state_d = S_OUT;
        endcase
      end
      // every visited node is read, the last one too for its next link
      S_WALK: state_d = S_RD;
      S_RD: state_d = S_WAIT;
      S_WAIT: state_d = sts_i.walk_done ? S_LINK : S_WALK;
      S_LINK: state_d = S_OUT;
      S_DUMP_RD: state_d = S_DUMP_WAIT;
      S_DUMP_WAIT: state_d = S_DUMP_OUT;
      S_DUMP_OUT: if (out_ready_i) state_d = sts_i.nx_valid ? S_DUMP_RD : S_IDLE;
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT) || (state_q == S_DUMP_OUT);
    cmd_o.op     = OP_NONE;
    cmd_o.status = ST_DONE;
    case (state_q)
      S_INIT: cmd_o.op = OP_INIT_STEP;
      S_IDLE: if (in_valid_i) cmd_o.op = OP_LOAD;
      S_DECODE: begin
        cmd_o.op = OP_START;
        case (mode_q)
          MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_POS:
            if (sts_i.full) cmd_o.status = ST_FULL;
          MODE_DEL_POS, MODE_DUMP:
            if (sts_i.empty) cmd_o.status = ST_ABSENT;
          default: cmd_o.status = ST_DONE;
        endcase
      end
      S_RD: cmd_o.op = OP_READ;
      S_WAIT: cmd_o.op = OP_STEP;
      S_LINK: begin
        case (mode_q)
          MODE_INS_HEAD: cmd_o.op = OP_INS_HEAD;
          MODE_INS_TAIL: cmd_o.op = OP_INS_TAIL;
          MODE_INS_POS: begin
            if (sts_i.del_head) cmd_o.op = OP_INS_HEAD;
            else if (!sts_i.cur_valid || !sts_i.nx_valid) cmd_o.op = OP_INS_TAIL;
            else cmd_o.op = OP_INS_MID;
          end
          default: begin
            if (sts_i.del_head || (sts_i.cur_valid && sts_i.prv_valid)) cmd_o.op = OP_DEL;
            else cmd_o.status = ST_ABSENT;
          end
        endcase
        if (cmd_o.op != OP_NONE) cmd_o.status = ST_DONE;
        else cmd_o.op = OP_RESULT;
      end
      S_DUMP_RD: cmd_o.op = OP_READ;
      S_DUMP_WAIT: cmd_o.op = OP_DUMP_EMIT;
      S_DUMP_OUT: if (out_ready_i) cmd_o.op = OP_STEP;
      default: cmd_o.op = OP_NONE;
    endcase
  end
endmodule

// ===== sv/pdll_dp.sv =====
module pdll_dp #(
  parameter int Capacity   = 64,
  parameter int ValueWidth = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [2:0]            mode_i,
  input  logic [6:0]            position_i,
  input  logic [ValueWidth-1:0] value_i,
  input  logic                  out_ready_i,
  input  pdll_pkg::pdll_cmd_t   cmd_i,
  output pdll_pkg::pdll_sts_t   sts_o,
  output logic [ValueWidth-1:0] value_o,
  output logic                  last_o,
  output logic [1:0]            status_o,
  output logic [6:0]            length_o
);
  import pdll_pkg::*;

  localparam int AW = $clog2(Capacity);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] NoneIdx = LW'(Capacity);

  logic [LW-1:0] head_q, tail_q, free_q, cur_q, prv_q, nx_q;
  logic [6:0] count_q, pos_q, cnt_q;
  logic [2:0] mode_q;
  logic [ValueWidth-1:0] val_q, out_val_q;
  logic [1:0] status_q;
  logic last_q, initd_q;
  logic [LW-1:0] init_q;

  // two link memories plus value store, one write port each
  logic nw_we, pw_we, vw_we;
  logic [AW-1:0] nw_a, pw_a, raddr;
  logic [LW-1:0] nw_d, pw_d, next_rd, prev_rd;
  logic [ValueWidth-1:0] val_rd;
  // second next-link and prev-link writes for ops touching two nodes (kept in small regs)
  logic n2_pend_q, p2_pend_q;
  logic [AW-1:0] n2_a_q, p2_a_q;
  logic [LW-1:0] n2_d_q, p2_d_q;
  // free chain successor: live read right after start, held copy later
  logic start_q, fin_q;
  logic [LW-1:0] free_nx_q, free_nx;

  pdll_ram #(.Width(LW), .Depth(Capacity)) u_next (
    .clk_i, .we_i(nw_we), .waddr_i(nw_a), .wdata_i(nw_d),
    .raddr_i(raddr), .rdata_o(next_rd));
  pdll_ram #(.Width(LW), .Depth(Capacity)) u_prev (
    .clk_i, .we_i(pw_we), .waddr_i(pw_a), .wdata_i(pw_d),
    .raddr_i(raddr), .rdata_o(prev_rd));
  pdll_ram #(.Width(ValueWidth), .Depth(Capacity)) u_val (
    .clk_i, .we_i(vw_we), .waddr_i(free_q[AW-1:0]), .wdata_i(val_q),
    .raddr_i(raddr), .rdata_o(val_rd));

  assign free_nx = start_q ? next_rd : free_nx_q;

  logic [6:0] tgt;
  always_comb begin
    // insert walks to pos-1, delete to pos
    tgt = (mode_q == MODE_DEL_POS) ? pos_q : pos_q - 7'd1;
    sts_o.init_done = initd_q;
    sts_o.full      = (free_q == NoneIdx);
    sts_o.empty     = (head_q == NoneIdx);
    sts_o.cur_valid = (cur_q != NoneIdx);
    sts_o.prv_valid = (prv_q != NoneIdx);
    sts_o.nx_valid  = (nx_q != NoneIdx);
    sts_o.del_head  = (pos_q <= 7'd1);
    sts_o.walk_done = sts_o.del_head || (cnt_q >= tgt) || (cur_q == NoneIdx);
  end

  // read address: node under the walk pointer, or free head on start
  assign raddr = (cmd_i.op == OP_START) ? free_q[AW-1:0] : cur_q[AW-1:0];

  logic [LW-1:0] nn;
  assign nn = free_q;

  always_comb begin
    nw_we = 1'b0; nw_a = '0; nw_d = '0;
    pw_we = 1'b0; pw_a = '0; pw_d = '0;
    vw_we = 1'b0;
    if (!initd_q) begin
      nw_we = 1'b1; nw_a = init_q[AW-1:0]; nw_d = init_q + LW'(1);
      pw_we = 1'b1; pw_a = init_q[AW-1:0]; pw_d = NoneIdx;
    end else begin
      if (n2_pend_q) begin
        nw_we = 1'b1; nw_a = n2_a_q; nw_d = n2_d_q;
      end
      if (p2_pend_q) begin
        pw_we = 1'b1; pw_a = p2_a_q; pw_d = p2_d_q;
      end
      case (cmd_i.op)
        OP_INS_HEAD: begin
          vw_we = 1'b1;
          nw_we = 1'b1; nw_a = nn[AW-1:0]; nw_d = head_q;
          pw_we = 1'b1; pw_a = nn[AW-1:0]; pw_d = NoneIdx;
        end
        OP_INS_TAIL: begin
          vw_we = 1'b1;
          nw_we = 1'b1; nw_a = nn[AW-1:0]; nw_d = NoneIdx;
          pw_we = 1'b1; pw_a = nn[AW-1:0]; pw_d = tail_q;
        end
        OP_INS_MID: begin
          vw_we = 1'b1;
          nw_we = 1'b1; nw_a = nn[AW-1:0]; nw_d = nx_q;
          pw_we = 1'b1; pw_a = nn[AW-1:0]; pw_d = cur_q;
        end
        OP_DEL: begin
          // released node goes onto the free chain
          nw_we = 1'b1; nw_a = cur_q[AW-1:0]; nw_d = free_q;
          pw_we = 1'b1; pw_a = cur_q[AW-1:0]; pw_d = NoneIdx;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= NoneIdx; tail_q <= NoneIdx; free_q <= '0;
      count_q <= '0; initd_q <= 1'b0; init_q <= '0;
      n2_pend_q <= 1'b0; p2_pend_q <= 1'b0;
      n2_a_q <= '0; p2_a_q <= '0; n2_d_q <= '0; p2_d_q <= '0;
      cur_q <= NoneIdx; prv_q <= NoneIdx; nx_q <= NoneIdx;
      cnt_q <= '0; pos_q <= '0; mode_q <= '0;
      status_q <= ST_DONE; last_q <= 1'b0;
    end else begin
      n2_pend_q <= 1'b0;
      p2_pend_q <= 1'b0;
      if (!initd_q) begin
        init_q <= init_q + LW'(1);
        if (init_q == LW'(Capacity - 1)) initd_q <= 1'b1;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          mode_q <= mode_i; pos_q <= position_i;
        end
        OP_START: begin
          status_q <= cmd_i.status; last_q <= 1'b1;
          cur_q <= head_q; prv_q <= NoneIdx; cnt_q <= 7'd1;
          nx_q <= NoneIdx;
        end
        OP_READ: ;
        OP_STEP: begin
          if (mode_q == MODE_DUMP) begin
            cur_q <= nx_q;
          end else if (!sts_o.walk_done) begin
            prv_q <= cur_q; cur_q <= next_rd; cnt_q <= cnt_q + 7'd1;
          end
        end
        OP_DUMP_EMIT: begin
          nx_q <= next_rd;
          last_q <= (next_rd == NoneIdx);
          status_q <= ST_DONE;
        end
        default: ;
      endcase
      if (cmd_i.op == OP_RESULT) status_q <= cmd_i.status;
      if (cmd_i.op == OP_INS_HEAD) begin
        free_q <= free_nx; count_q <= count_q + 7'd1; head_q <= nn;
        if (head_q != NoneIdx) begin
          p2_pend_q <= 1'b1; p2_a_q <= head_q[AW-1:0]; p2_d_q <= nn;
        end else tail_q <= nn;
        status_q <= ST_DONE;
      end
      if (cmd_i.op == OP_INS_TAIL) begin
        free_q <= free_nx; count_q <= count_q + 7'd1; tail_q <= nn;
        if (tail_q != NoneIdx) begin
          n2_pend_q <= 1'b1; n2_a_q <= tail_q[AW-1:0]; n2_d_q <= nn;
        end else head_q <= nn;
        status_q <= ST_DONE;
      end
      if (cmd_i.op == OP_INS_MID) begin
        free_q <= free_nx; count_q <= count_q + 7'd1;
        n2_pend_q <= 1'b1; n2_a_q <= cur_q[AW-1:0]; n2_d_q <= nn;
        p2_pend_q <= 1'b1; p2_a_q <= nx_q[AW-1:0]; p2_d_q <= nn;
        status_q <= ST_DONE;
      end
      if (cmd_i.op == OP_DEL) begin
        free_q <= cur_q; count_q <= count_q - 7'd1;
        if (nx_q != NoneIdx) begin
          p2_pend_q <= 1'b1; p2_a_q <= nx_q[AW-1:0]; p2_d_q <= prv_q;
        end else tail_q <= prv_q;
        if (prv_q == NoneIdx) head_q <= nx_q;
        else begin
          n2_pend_q <= 1'b1; n2_a_q <= prv_q[AW-1:0]; n2_d_q <= nx_q;
        end
        status_q <= ST_DONE;
      end
      // the link ram read of the node reached, captured in the cycle after its address
      if (cmd_i.op == OP_STEP && mode_q != MODE_DUMP && sts_o.walk_done) nx_q <= next_rd;
      if (cmd_i.op == OP_READ && mode_q != MODE_DUMP) nx_q <= NoneIdx;
    end
  end

  // free head's next link and walk reads come back in the cycle after address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      start_q <= (cmd_i.op == OP_START);
      fin_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) val_q <= value_i;
    if (cmd_i.op == OP_DUMP_EMIT) out_val_q <= val_rd;
    else if (cmd_i.op == OP_START) out_val_q <= '0;
  end

  // free chain successor latched right after start
  always_ff @(posedge clk_i) begin
    if (start_q) free_nx_q <= next_rd;
  end

  assign value_o  = out_val_q;
  assign last_o   = last_q | fin_q;
  assign status_o = status_q;
  assign length_o = count_q;
  logic unused;
  assign unused = out_ready_i ^ free_nx_q[0] ^ prev_rd[0];
endmodule

// ===== sv/positional_doubly_linked_list_core.sv =====
// positional doubly linked list core
// input channel s_axis: mode, position, value_in; a request is taken when
// tvalid and tready are both high. output channel m_axis returns one result
// per request, or one per element for a dump with tlast on the final one.
// with a ready receiver, head/tail insert needs no walk; positional insert or
// delete walks the list one link at a time (up to CAPACITY links), a dump reads
// one element at a time, and a full pool, empty list or unused mode skips the walk;
// the walk is set by the single registered read port of the link memories.
// one request is in flight at a time; s_axis_tready is low until the last
// result is taken. a stalled receiver holds the result steady.
// after reset the free chain of CAPACITY nodes is built one node per cycle,
// during which no request is taken.
module positional_doubly_linked_list_core #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [((VALUE_WIDTH + 17) / 8) * 8 - 1:0] s_axis_tdata,
                                      // mode[2:0], position[9:3], value_in[41:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((VALUE_WIDTH + 17) / 8) * 8 - 1:0] m_axis_tdata,
                                      // value_out[31:0], status[33:32], length[40:34],
                                      // empty_res[41]
  output logic        m_axis_tlast
);
  import pdll_pkg::*;

  localparam int TdataWidth = ((VALUE_WIDTH + 17) / 8) * 8;

  pdll_cmd_t cmd;
  pdll_sts_t sts;
  logic [VALUE_WIDTH-1:0] vout;
  logic [1:0] st;
  logic [6:0] len;

  pdll_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tdata[2:0]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd));

  pdll_dp #(.Capacity(CAPACITY), .ValueWidth(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .load_i(s_axis_tvalid && s_axis_tready),
    .mode_i(s_axis_tdata[2:0]), .position_i(s_axis_tdata[9:3]),
    .value_i(s_axis_tdata[VALUE_WIDTH+9:10]),
    .out_ready_i(m_axis_tready),
    .cmd_i(cmd), .sts_o(sts),
    .value_o(vout), .last_o(m_axis_tlast), .status_o(st), .length_o(len));

  assign m_axis_tdata = TdataWidth'({(len == 7'd0), len, st, vout});
endmodule
